// ===== src/xsrng_pkg.sv =====
// Shared types, constants and the xoshiro256** step for the bounded-size PRNG.
// No dependencies; used by xoshiro256ss_prng_with_range_top and its checker.
package xsrng_pkg;

   localparam int DEF_SIZE_BITS = 32;
   localparam int WORD_W        = 64;
   localparam int SIZE_W        = 32;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int KIND_W        = 2;
   localparam int BIT_CNT_W     = $clog2(WORD_W);
   localparam int RSP_DATA_W    = 96;

   localparam logic [WORD_W-1:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL2   = 64'h94d049bb133111eb;

   localparam logic [CSR_IDX_W-1:0] REG_FIXED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX   = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_SEED = 2'd0,
      KIND_WORD = 2'd1,
      KIND_SIZE = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef logic [3:0][WORD_W-1:0] gen_state_type;

   typedef struct packed {
      gen_state_type        gen;
      logic [WORD_W-1:0]    res;
   } draw_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic draw_type draw_next(input gen_state_type s);
      logic [WORD_W-1:0] x5;
      logic [WORD_W-1:0] r7;
      logic [WORD_W-1:0] t;
      gen_state_type     n;
      x5 = (s[1] << 2) + s[1];
      r7 = rotl(x5, 7);
      t  = s[1] << 17;
      n[2] = s[2] ^ s[0];
      n[3] = s[3] ^ s[1];
      n[1] = s[1] ^ n[2];
      n[0] = s[0] ^ n[3];
      n[2] = n[2] ^ t;
      n[3] = rotl(n[3], 45);
      draw_next.gen = n;
      draw_next.res = (r7 << 3) + r7;
   endfunction

endpackage

// ===== src/xoshiro256ss_prng_with_range_top.sv =====
// xoshiro256** generator with splitmix64 reseed and a bounded size draw.
// Depends on xsrng_pkg.
//
// A word draw, a fixed-size draw and an inverted-range draw finish in the
// accept cycle; an in-range size draw sets up in the accept cycle and then runs
// the one-bit-per-cycle restoring remainder unit over the drawn word; a reseed
// runs four splitmix64 rounds after the accept cycle, each on one shared
// 32x32 multiplier. One word is in work at a time,
// and a new word is taken once the result register is empty or draining.
// Kind 3 is dropped without a result. After reset the state is all zero and
// word draws return zero until a reseed.
module xoshiro256ss_prng_with_range_top
   import xsrng_pkg::*;
#(
   parameter int SIZE_BITS = DEF_SIZE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [WORD_W-1:0]     req_tdata,   // [63:0] seed_value
   input  logic [KIND_W-1:0]     req_tuser,   // [1:0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [63:0] word, [95:64] size
   output logic                  rsp_tuser,   // [0] bad_range
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int REG_W = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MIX  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   gen_state_type      gen_ff, gen_in;
   logic [REG_W-1:0]   fixed_ff, fixed_in;
   logic [REG_W-1:0]   min_ff, min_in;
   logic [REG_W-1:0]   max_ff, max_in;
   logic [WORD_W-1:0]  acc_ff, acc_in;
   logic [WORD_W-1:0]  x_ff, x_in;
   logic [WORD_W-1:0]  z_ff, z_in;
   logic [1:0]         mcnt_ff, mcnt_in;
   logic               phase_ff, phase_in;
   logic [1:0]         idx_ff, idx_in;
   logic [WORD_W-1:0]  dvd_ff, dvd_in;
   logic [REG_W:0]     rem_ff, rem_in;
   logic [REG_W:0]     span_ff, span_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [SIZE_W-1:0]  rsp_size_ff, rsp_size_in;
   logic               rsp_bad_ff, rsp_bad_in;

   draw_type           draw;
   logic [WORD_W-1:0]  mul_const;
   logic [31:0]        mul_a, mul_b;
   logic [WORD_W-1:0]  prod;
   logic [WORD_W-1:0]  z_sum;
   logic [WORD_W-1:0]  acc_sum;
   logic [REG_W:0]     span_w;
   logic [REG_W+1:0]   trial;
   logic [REG_W+1:0]   diff;
   logic [REG_W:0]     rem_new;
   logic [REG_W-1:0]   size_sum;
   logic               req_take;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_size_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_bad_ff;

   assign draw      = draw_next(gen_ff);
   assign mul_const = phase_ff ? MIX_MUL2 : MIX_MUL1;
   assign mul_a     = (mcnt_ff == 2'd1) ? x_ff[63:32] : x_ff[31:0];
   assign mul_b     = (mcnt_ff == 2'd2) ? mul_const[63:32] : mul_const[31:0];
   assign prod      = WORD_W'(mul_a) * WORD_W'(mul_b);
   assign z_sum     = (mcnt_ff == 2'd0) ? prod : z_ff + {prod[31:0], 32'd0};
   assign acc_sum   = acc_ff + MIX_GOLDEN;
   assign span_w    = {1'b0, max_ff} - {1'b0, min_ff} + (REG_W+1)'(1);
   assign trial     = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff      = trial - {1'b0, span_ff};
   assign rem_new   = (trial >= {1'b0, span_ff}) ? diff[REG_W:0] : trial[REG_W:0];
   assign size_sum  = min_ff + rem_new[REG_W-1:0];

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      fixed_in     = fixed_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      z_in         = z_ff;
      mcnt_in      = mcnt_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      span_in      = span_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_bad_in   = rsp_bad_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_FIXED: fixed_in = csr_data[REG_W-1:0];
            REG_MIN:   min_in   = csr_data[REG_W-1:0];
            REG_MAX:   max_in   = csr_data[REG_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (kind_type'(req_tuser))
                  KIND_SEED: begin
                     acc_in   = req_tdata;
                     idx_in   = 2'd0;
                     state_in = ST_MIX;
                  end
                  KIND_WORD: begin
                     gen_in       = draw.gen;
                     rsp_word_in  = draw.res;
                     rsp_size_in  = '0;
                     rsp_bad_in   = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  KIND_SIZE: begin
                     rsp_word_in = '0;
                     rsp_bad_in  = 1'b0;
                     if (fixed_ff != '0) begin
                        rsp_size_in  = SIZE_W'(fixed_ff);
                        rsp_valid_in = 1'b1;
                     end else begin
                        gen_in = draw.gen;
                        if (max_ff < min_ff) begin
                           rsp_size_in  = SIZE_W'(min_ff);
                           rsp_bad_in   = 1'b1;
                           rsp_valid_in = 1'b1;
                        end else begin
                           dvd_in   = draw.res;
                           rem_in   = '0;
                           span_in  = span_w;
                           cnt_in   = '1;
                           state_in = ST_DIV;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MIX: begin
            acc_in   = acc_sum;
            x_in     = acc_sum ^ (acc_sum >> 30);
            phase_in = 1'b0;
            mcnt_in  = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mcnt_ff != 2'd2) begin
               z_in    = z_sum;
               mcnt_in = mcnt_ff + 2'd1;
            end else if (!phase_ff) begin
               x_in     = z_sum ^ (z_sum >> 27);
               phase_in = 1'b1;
               mcnt_in  = 2'd0;
            end else begin
               gen_in[idx_ff] = z_sum ^ (z_sum >> 31);
               if (idx_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_MIX;
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_new;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - BIT_CNT_W'(1);
            if (cnt_ff == '0) begin
               rsp_size_in  = SIZE_W'(size_sum);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= '0;
         fixed_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mcnt_ff      <= '0;
         phase_ff     <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         fixed_ff     <= fixed_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         mcnt_ff      <= mcnt_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      z_ff        <= z_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      span_ff     <= span_in;
      rsp_word_ff <= rsp_word_in;
      rsp_size_ff <= rsp_size_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

endmodule

// ===== src/xsrng_checker.sv =====
// Port-level checks for xoshiro256ss_prng_with_range_top, bound to the top level.
// Depends on xsrng_pkg.
module xsrng_checker
   import xsrng_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [KIND_W-1:0]     req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic req_take;
   assign req_take = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_word_now: assert property (@(posedge clock) disable iff (reset)
      req_take && req_tuser == KIND_WORD |=>
         rsp_tvalid && rsp_tdata[95:64] == '0 && !rsp_tuser)
      else $error("word draw did not give a word result next cycle");

   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_tuser == KIND_SEED || req_tuser == KIND_NONE) |=> !rsp_tvalid)
      else $error("reseed or unused kind gave a result");

   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[63:0] == '0)
      else $error("bad range result carries a word");

endmodule

bind xoshiro256ss_prng_with_range_top xsrng_checker u_xsrng_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for xoshiro256ss_prng_with_range_top: reseed, raw word and
// bounded size draws against an in-bench xoshiro256**/splitmix64 predictor.
// Depends on xsrng_pkg and the top module; stalls both stream sides at random.
module tb_top;
   import xsrng_pkg::*;

   localparam logic [63:0] SM_STEP = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SM_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] SM_MUL_B = 64'h94d049bb133111eb;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] seed;
   } gen_request_t;

   typedef struct {
      bit          produced;
      logic [63:0] word;
      logic [31:0] size;
      logic        bad;
   } draw_out_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic [63:0]  gen_q [4] = '{default: 64'd0};
   logic [31:0]  cfg_fixed = '0;
   logic [31:0]  cfg_min = '0;
   logic [31:0]  cfg_max = '0;

   gen_request_t requests[$];
   draw_out_t    draws_due[$];
   gen_request_t cur_req;
   draw_out_t    fresh, seen;
   int           errors = 0;
   int           words_seen = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   int           gap_pct = 25;
   int           stall_pct = 25;
   bit           steady = 1'b0;

   xoshiro256ss_prng_with_range_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] rol64(input logic [63:0] v, input int n);
      return (v << n) | (v >> (64 - n));
   endfunction

   function automatic logic [63:0] splitmix_next(inout logic [63:0] acc);
      logic [63:0] z;
      acc = acc + SM_STEP;
      z = acc;
      z = (z ^ (z >> 30)) * SM_MUL_A;
      z = (z ^ (z >> 27)) * SM_MUL_B;
      return z ^ (z >> 31);
   endfunction

   function automatic logic [63:0] advance_generator();
      logic [63:0] out;
      logic [63:0] t;
      out = rol64(gen_q[1] * 64'd5, 7) * 64'd9;
      t = gen_q[1] << 17;
      gen_q[2] = gen_q[2] ^ gen_q[0];
      gen_q[3] = gen_q[3] ^ gen_q[1];
      gen_q[1] = gen_q[1] ^ gen_q[2];
      gen_q[0] = gen_q[0] ^ gen_q[3];
      gen_q[2] = gen_q[2] ^ t;
      gen_q[3] = rol64(gen_q[3], 45);
      return out;
   endfunction

   function automatic draw_out_t run_generator(input gen_request_t rq);
      draw_out_t   d;
      logic [63:0] acc;
      logic [63:0] raw;
      logic [63:0] span;
      logic [63:0] sum;
      d = '{produced: 1'b0, word: '0, size: '0, bad: 1'b0};
      case (rq.kind)
         KIND_SEED: begin
            acc = rq.seed;
            for (int i = 0; i < 4; i++) gen_q[i] = splitmix_next(acc);
         end
         KIND_WORD: begin
            d.produced = 1'b1;
            d.word = advance_generator();
         end
         KIND_SIZE: begin
            d.produced = 1'b1;
            if (cfg_fixed != 0) begin
               d.size = cfg_fixed;
            end else begin
               raw = advance_generator();
               if (cfg_max < cfg_min) begin
                  d.size = cfg_min;
                  d.bad = 1'b1;
               end else begin
                  span = {32'd0, cfg_max} - {32'd0, cfg_min} + 64'd1;
                  sum = {32'd0, cfg_min} + raw % span;
                  d.size = sum[31:0];
               end
            end
         end
         default: ;
      endcase
      return d;
   endfunction

   // sender: hold the word until taken, then idle or offer the next one
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            fresh = run_generator(cur_req);
            if (fresh.produced) draws_due = {draws_due, fresh};
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < gap_pct) begin
               gap_left = $urandom_range(0, 9);
               req_tvalid <= 1'b0;
            end else begin
               cur_req = requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= cur_req.seed;
               req_tuser <= cur_req.kind;
            end
         end
      end
   end

   // receiver: check each word against the oldest prediction, then stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen = words_seen + 1;
            if (words_seen == 300 || words_seen == 1200) hold_left = HOLD_CYCLES;
            if (draws_due.size() == 0) begin
               errors = errors + 1;
               $display("%0t: unexpected word, expected none, actual tdata=%h tuser=%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               seen = draws_due.pop_front();
               if (rsp_tdata[63:0] !== seen.word) begin
                  errors = errors + 1;
                  $display("%0t: word mismatch, expected %h, actual %h",
                           $time, seen.word, rsp_tdata[63:0]);
               end
               if (rsp_tdata[95:64] !== seen.size) begin
                  errors = errors + 1;
                  $display("%0t: size mismatch, expected %h, actual %h",
                           $time, seen.size, rsp_tdata[95:64]);
               end
               if (rsp_tuser !== seen.bad) begin
                  errors = errors + 1;
                  $display("%0t: bad_range mismatch, expected %b, actual %b",
                           $time, seen.bad, rsp_tuser);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_item(input kind_type k, input logic [63:0] s);
      gen_request_t item;
      item.kind = k;
      item.seed = s;
      requests = {requests, item};
   endtask

   task automatic queue_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) queue_item(KIND_SEED, {$urandom, $urandom});
      else if (r < 45) queue_item(KIND_WORD, {$urandom, $urandom});
      else if (r < 95) queue_item(KIND_SIZE, {$urandom, $urandom});
      else queue_item(KIND_NONE, {$urandom, $urandom});
   endtask

   // drain everything, then let a reseed or dropped word finish inside the block
   task automatic settle();
      do @(negedge clock);
      while (requests.size() != 0 || req_tvalid || draws_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_FIXED: cfg_fixed = val;
         REG_MIN:   cfg_min = val;
         REG_MAX:   cfg_max = val;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hffffffff;
         2: return $urandom_range(0, 20);
         3: return $urandom;
         default: return $urandom_range(0, 1000);
      endcase
   endfunction

   initial begin
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] t;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      queue_item(KIND_WORD, 64'd0);
      queue_item(KIND_WORD, 64'hffffffffffffffff);
      queue_item(KIND_SIZE, 64'd0);
      queue_item(KIND_NONE, 64'hffffffffffffffff);
      queue_item(KIND_SEED, 64'd0);
      queue_item(KIND_WORD, 64'd0);
      queue_item(KIND_SIZE, 64'd0);
      queue_item(KIND_SEED, 64'hffffffffffffffff);
      queue_item(KIND_WORD, 64'd0);
      queue_item(KIND_SEED, 64'h5555555555555555);
      queue_item(KIND_SEED, 64'haaaaaaaaaaaaaaaa);
      queue_item(KIND_WORD, 64'd0);
      queue_item(KIND_SIZE, 64'd0);
      settle();

      write_reg(REG_FIXED, 32'hffffffff);
      queue_item(KIND_SIZE, 64'd0);
      queue_item(KIND_WORD, 64'd0);
      queue_item(KIND_SIZE, 64'd0);
      settle();

      write_reg(REG_FIXED, 32'd1);
      write_reg(REG_SPARE, 32'h00001234);
      queue_item(KIND_SIZE, 64'd0);
      settle();

      write_reg(REG_FIXED, 32'd0);
      write_reg(REG_MIN, 32'd5);
      write_reg(REG_MAX, 32'd3);
      queue_item(KIND_SIZE, 64'd0);
      queue_item(KIND_WORD, 64'd0);
      settle();

      write_reg(REG_MIN, 32'd0);
      write_reg(REG_MAX, 32'hffffffff);
      queue_item(KIND_SIZE, 64'd0);
      queue_item(KIND_SIZE, 64'd0);
      settle();

      write_reg(REG_MIN, 32'hffffffff);
      queue_item(KIND_SIZE, 64'd0);
      settle();

      write_reg(REG_MAX, 32'd0);
      queue_item(KIND_SIZE, 64'd0);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         gap_pct = (ph == 0) ? 0 : 20 * $urandom_range(1, 2);
         stall_pct = (ph == 0) ? 0 : 20 * $urandom_range(1, 2);
         write_reg(REG_FIXED, ($urandom_range(0, 3) == 0) ? pick_bound() : 32'd0);
         lo = pick_bound();
         hi = pick_bound();
         if ($urandom_range(0, 2) != 0 && hi < lo) begin
            t = lo;
            lo = hi;
            hi = t;
         end
         write_reg(REG_MIN, lo);
         write_reg(REG_MAX, hi);
         steady = (ph == 5);
         repeat (300) queue_random();
         settle();
      end

      if (errors == 0 && draws_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
